// ----- rtl/btl_pkg.sv -----
// Package for the bucketed token limiter: table sizes, operation and
// category codes, register indexes and the controller/datapath interface types.
// No dependencies.
package btl_pkg;

  // Bucket counts of the three tables.
  localparam int GROUP_BUCKETS         = 128;
  localparam int NORMAL_SENDER_BUCKETS = 128;
  localparam int LOW_SENDER_BUCKETS    = 128;

  localparam int NUM_TABLES = 3;

  localparam int MAX_BUCKETS_GN = (GROUP_BUCKETS > NORMAL_SENDER_BUCKETS) ?
                                  GROUP_BUCKETS : NORMAL_SENDER_BUCKETS;
  localparam int MAX_BUCKETS    = (MAX_BUCKETS_GN > LOW_SENDER_BUCKETS) ?
                                  MAX_BUCKETS_GN : LOW_SENDER_BUCKETS;
  localparam int SWEEP_AW       = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

  // Field widths.
  localparam int FUNC_W  = 2;
  localparam int CAT_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int TOK_W   = 8;
  localparam int BDEN_W  = 16;
  localparam int CDEN_W  = 32;
  localparam int ENTRY_W = BDEN_W + TOK_W;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TAKE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REFILL = 2'd2;

  // Category codes.
  localparam logic [CAT_W-1:0] CAT_GROUP  = 2'd0;
  localparam logic [CAT_W-1:0] CAT_NORMAL = 2'd1;
  localparam logic [CAT_W-1:0] CAT_LOW    = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_CAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_CAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CAP    = 2'd2;

  // Reset values of the caps.
  localparam logic [TOK_W-1:0] GROUP_CAP_RST  = 8'd8;
  localparam logic [TOK_W-1:0] NORMAL_CAP_RST = 8'd8;
  localparam logic [TOK_W-1:0] LOW_CAP_RST    = 8'd4;

  // Reserved sender hash bytes and the bucket denial ceiling.
  localparam logic [BYTE_W-1:0] HASH_RSV_LOW  = 8'h00;
  localparam logic [BYTE_W-1:0] HASH_RSV_HIGH = 8'hFF;
  localparam logic [BDEN_W-1:0] BDEN_SAT      = 16'hFFFF;

  // Bucket count of a table, by category code.
  function automatic int tbl_size(int t);
    int s;
    case (t)
      0:       s = GROUP_BUCKETS;
      1:       s = NORMAL_SENDER_BUCKETS;
      default: s = LOW_SENDER_BUCKETS;
    endcase
    return s;
  endfunction

  // Source of the table read address.
  typedef enum logic [1:0] {
    RD_IN    = 2'd0,
    RD_ITEM  = 2'd1,
    RD_SWEEP = 2'd2
  } rd_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    cap_item;
    logic    rd_en;
    rd_src_e rd_src;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    fill_wr;
    logic    clr_wr;
    logic    resolve;
  } btl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_refill;
    logic sweep_last;
  } btl_sts_t;

endpackage

// ----- rtl/btl_ctrl.sv -----
// Controller of the bucketed token limiter: sequences the clearing pass after
// reset, the read-modify-write of one transaction, the refill sweep and the
// output register handshake. Depends on btl_pkg.
module btl_ctrl import btl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  btl_sts_t sts_i,
  output btl_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_RESOLVE = 6'b000100,
    S_FILL_RD = 6'b001000,
    S_FILL_WR = 6'b010000,
    S_LOOK    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '{cap_item: 1'b0, rd_en: 1'b0, rd_src: RD_IN, cnt_clr: 1'b0,
                cnt_inc: 1'b0, fill_wr: 1'b0, clr_wr: 1'b0, resolve: 1'b0};
    unique case (state_q)
      S_CLEAR: begin
        // Zero one entry of every table per cycle after reset.
        cmd_o.clr_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.cap_item = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_src   = RD_IN;
          if (sts_i.in_refill) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_FILL_RD;
          end else begin
            state_d = S_RESOLVE;
          end
        end
      end
      S_FILL_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RD_SWEEP;
        state_d      = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_LOOK;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_FILL_RD;
        end
      end
      S_LOOK: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RD_ITEM;
        state_d      = S_RESOLVE;
      end
      S_RESOLVE: begin
        // The update waits until the output register has room.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.resolve = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.resolve) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/btl_datapath.sv -----
// Datapath of the bucketed token limiter: bucket tables, caps, category
// denial totals, sweep counter and the result register.
// Depends on btl_pkg.
module btl_datapath import btl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          in_data_i,
  input  logic [3:0]           in_user_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TOK_W-1:0]     cfg_wdata_i,
  input  btl_cmd_t             cmd_i,
  output btl_sts_t             sts_o,
  output logic [63:0]          out_data_o
);

  logic [FUNC_W-1:0]   in_func;
  logic [BYTE_W-1:0]   in_idx;
  logic [FUNC_W-1:0]   func_q;
  logic [CAT_W-1:0]    cat_q;
  logic [BYTE_W-1:0]   hash_q;
  logic [BYTE_W-1:0]   idx_q;
  logic [TOK_W-1:0]    cap_q [NUM_TABLES];
  logic [CDEN_W-1:0]   tot_q [NUM_TABLES];
  logic [SWEEP_AW-1:0] cnt_q;

  logic [TOK_W-1:0]    tok_cur [NUM_TABLES];
  logic [BDEN_W-1:0]   den_cur [NUM_TABLES];
  logic [NUM_TABLES-1:0] inr;

  logic                cat_ok;
  logic                s_inr;
  logic [TOK_W-1:0]    s_tok;
  logic [BDEN_W-1:0]   s_den;
  logic [CDEN_W-1:0]   s_tot;
  logic                reserved, take, allowed, deny, den_bump, show;
  logic [TOK_W-1:0]    tok_new;
  logic [BDEN_W-1:0]   den_new;
  logic [CDEN_W-1:0]   tot_new;

  logic                allowed_q;
  logic [TOK_W-1:0]    tokens_q;
  logic [BDEN_W-1:0]   bden_q;
  logic [CDEN_W-1:0]   cden_q;

  assign in_func = in_user_i[FUNC_W-1:0];
  assign in_idx  = in_data_i[15:8];

  assign sts_o.in_refill  = (in_func == FUNC_REFILL);
  assign sts_o.sweep_last = (cnt_q == SWEEP_AW'(MAX_BUCKETS - 1));

  // Item capture at acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      func_q <= in_func;
      cat_q  <= in_user_i[3:2];
      hash_q <= in_data_i[7:0];
      idx_q  <= in_idx;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q[0] <= GROUP_CAP_RST;
      cap_q[1] <= NORMAL_CAP_RST;
      cap_q[2] <= LOW_CAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GROUP_CAP:  cap_q[0] <= cfg_wdata_i;
        CFG_NORMAL_CAP: cap_q[1] <= cfg_wdata_i;
        CFG_LOW_CAP:    cap_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sweep counter, shared by the clearing pass and the refill.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + SWEEP_AW'(1);
    end
  end

  // One table per category: entries hold {bucket denials, tokens}; the
  // clearing pass after reset zeroes every entry.
  for (genvar g = 0; g < NUM_TABLES; g++) begin : g_tbl
    localparam int SIZE = tbl_size(g);
    localparam int AW   = (SIZE > 1) ? $clog2(SIZE) : 1;

    logic [ENTRY_W-1:0] mem [SIZE];
    logic [ENTRY_W-1:0] rd_q;
    logic [AW-1:0]      ra, wa;
    logic               we, fill_on;
    logic [ENTRY_W-1:0] wd;

    always_comb begin
      unique case (cmd_i.rd_src)
        RD_IN:    ra = in_idx[AW-1:0];
        RD_ITEM:  ra = idx_q[AW-1:0];
        RD_SWEEP: ra = cnt_q[AW-1:0];
        default:  ra = idx_q[AW-1:0];
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.rd_en) begin
        rd_q <= mem[ra];
      end
    end

    assign tok_cur[g] = rd_q[TOK_W-1:0];
    assign den_cur[g] = rd_q[ENTRY_W-1:TOK_W];
    assign inr[g]     = ({1'b0, idx_q} < 9'(SIZE));
    assign fill_on    = ({1'b0, cnt_q} < (SWEEP_AW + 1)'(SIZE));

    // Write port: refill sweep, clearing pass or the update of a take.
    always_comb begin
      if (cmd_i.fill_wr) begin
        we = fill_on;
        wa = cnt_q[AW-1:0];
        wd = {den_cur[g], (tok_cur[g] < cap_q[g]) ? tok_cur[g] + TOK_W'(1) : tok_cur[g]};
      end else if (cmd_i.clr_wr) begin
        we = fill_on;
        wa = cnt_q[AW-1:0];
        wd = '0;
      end else begin
        we = cmd_i.resolve && cat_ok && (cat_q == CAT_W'(g)) && s_inr &&
             (allowed || den_bump);
        wa = idx_q[AW-1:0];
        wd = {den_new, tok_new};
      end
    end

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[wa] <= wd;
      end
    end
  end

  // Selection of the addressed table.
  assign cat_ok = (cat_q == CAT_GROUP) || (cat_q == CAT_NORMAL) || (cat_q == CAT_LOW);

  always_comb begin
    unique case (cat_q)
      CAT_GROUP:  begin s_inr = inr[0]; s_tok = tok_cur[0]; s_den = den_cur[0];
                        s_tot = tot_q[0]; end
      CAT_NORMAL: begin s_inr = inr[1]; s_tok = tok_cur[1]; s_den = den_cur[1];
                        s_tot = tot_q[1]; end
      CAT_LOW:    begin s_inr = inr[2]; s_tok = tok_cur[2]; s_den = den_cur[2];
                        s_tot = tot_q[2]; end
      default:    begin s_inr = 1'b0; s_tok = '0; s_den = '0; s_tot = '0; end
    endcase
  end

  // Take decision and updated values.
  assign reserved = cat_ok && (cat_q != CAT_GROUP) &&
                    ((hash_q == HASH_RSV_LOW) || (hash_q == HASH_RSV_HIGH));
  assign take     = cat_ok && (func_q == FUNC_TAKE) && !reserved;
  assign allowed  = take && s_inr && (s_tok != '0);
  assign deny     = take && !allowed;
  assign den_bump = deny && s_inr && (s_den != BDEN_SAT);
  assign tok_new  = allowed ? s_tok - TOK_W'(1) : s_tok;
  assign den_new  = den_bump ? s_den + BDEN_W'(1) : s_den;
  assign tot_new  = deny ? s_tot + CDEN_W'(1) : s_tot;
  assign show     = cat_ok && !reserved && s_inr;

  // Category denial totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TABLES; i++) begin
        tot_q[i] <= '0;
      end
    end else if (cmd_i.resolve && deny) begin
      tot_q[cat_q] <= tot_new;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      allowed_q <= allowed;
      tokens_q  <= show ? tok_new : '0;
      bden_q    <= show ? den_new : '0;
      cden_q    <= cat_ok ? tot_new : '0;
    end
  end

  assign out_data_o = {7'd0, cden_q, bden_q, tokens_q, allowed_q};

endmodule

// ----- rtl/bucketed_token_limiter.sv -----
// Top level of the bucketed token limiter: joins controller and datapath.
// Depends on btl_pkg, btl_ctrl and btl_datapath.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata, tuser
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata
//  cfg       in         cfg_we_i                       cfg_idx_i, cfg_wdata_i
//
// Peek or take: the entry is read at acceptance; once the output register has
// room, the result is registered and a take writes the entry back. Refill: a
// sweep of one read and one write per entry, then a read of the item.
// Reset starts a clearing pass that zeroes one entry per table each cycle; the
// input stays off until the pass ends. A result waiting in the output register
// holds the next transaction before its write-back.
module bucketed_token_limiter import btl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // hash_byte[7:0], bucket_index[15:8]
  input  logic [3:0]           s_axis_tuser,  // func[1:0], category[3:2]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,  // allowed[0], tokens[8:1],
                                              // bucket_denials[24:9],
                                              // category_denials[56:25], zero[63:57]
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TOK_W-1:0]     cfg_wdata_i
);

  btl_cmd_t cmd;
  btl_sts_t sts;

  btl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  btl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

  // Only one transaction is in work at a time.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a transaction is in work");

  // A write-back always loads the output register.
  a_resolve_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.resolve |=> m_axis_tvalid)
    else $error("result not presented after write-back");

  // A refill starts its sweep right after acceptance.
  a_refill_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && sts.in_refill) |=>
      (cmd.rd_en && (cmd.rd_src == RD_SWEEP)))
    else $error("refill sweep did not start");

  // Write-back never coincides with a sweep write.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.resolve && cmd.fill_wr))
    else $error("write-back overlaps refill write");

endmodule
